>>> rtl/tgl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgl_pkg
// Shared types, constants and helper functions of the tissue gas loading unit.
// ----------------------------------------------------------------------------
package tgl_pkg;

    localparam int DIV_N = 40;
    localparam int DIV_M = 27;

    localparam logic [1:0] CFG_HALF_LIFE = 2'd0;
    localparam logic [1:0] CFG_COEFF_A   = 2'd1;
    localparam logic [1:0] CFG_COEFF_B   = 2'd2;
    localparam logic [1:0] CFG_VAPOUR    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNINIT    = 2'd1;
    localparam logic [1:0] ST_DEN_ZERO  = 2'd2;

    localparam logic REQ_SET    = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic load_in;
        logic set_press;
        logic div_start_exp;
        logic exp_cap;
        logic fact;
        logic mul_d;
        logic upd;
        logic tol_mul;
        logic tol_rnd;
        logic den_start;
        logic out_load;
        logic out_uninit;
    } t_cmd;

    typedef struct packed {
        logic req;
        logic press_valid;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic [16:0] f_exp2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    function automatic logic signed [27:0] f_round_q16(input logic signed [43:0] x);
        logic [43:0] mag;
        logic [27:0] r;
        mag = x[43] ? 44'(-x) : 44'(x);
        r   = 28'((mag + 44'd32768) >> 16);
        return x[43] ? $signed(-r) : $signed(r);
    endfunction

endpackage

>>> rtl/tissue_gas_loading_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tissue_gas_loading_unit
// One inert-gas tissue compartment with set and constant-pressure update.
// ----------------------------------------------------------------------------
// Input transactions arrive on i_valid/o_ready with the request type, the
// pressure value and the duration. Each one gives exactly one result
// transaction on o_valid/i_ready. Configuration writes use i_cfg_valid,
// o_cfg_ready (always high), i_cfg_index and i_cfg_data; the user must make
// them only while the unit is idle, which the block itself does not enforce.
// One transaction is processed at a time. A set runs the shared radix-2 divider
// once, for the gradient, and an update runs it twice, once for the exponent
// ratio and once for the gradient. An uninitialized update skips the arithmetic
// and goes straight to its final step. The next transaction can be accepted in
// the cycle after the result is loaded. The result sits in an output register,
// so a new transaction is accepted while it waits; a stalled receiver holds the
// result and the next one waits in its final step until the register is free.
// Reset restores the default coefficients and clears the tissue pressure and
// its initialized flag.
// ----------------------------------------------------------------------------
module tissue_gas_loading_unit
    import tgl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [23:0]        i_pressure_value,
    input  logic [19:0]        i_duration,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [23:0]        o_tissue_pressure,
    output logic signed [23:0] o_surface_tolerance,
    output logic signed [23:0] o_gradient,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tgl_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tgl_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_req_type          (i_req_type),
        .i_pressure_value    (i_pressure_value),
        .i_duration          (i_duration),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_tissue_pressure   (o_tissue_pressure),
        .o_surface_tolerance (o_surface_tolerance),
        .o_gradient          (o_gradient),
        .o_status            (o_status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Unit accepted a transaction without going busy.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("Result carries an undefined status code.");

    a_uninit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNINIT |-> o_tissue_pressure == 24'd0 && o_gradient == 24'sd0)
        else $error("Uninitialized result carries nonzero fields.");

    a_den_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DEN_ZERO |-> o_gradient == 24'sd0)
        else $error("Zero denominator result carries a nonzero gradient.");
endmodule

>>> rtl/tgl_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgl_divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgl_divider #(
    parameter int N = 40,
    parameter int M = 27
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);
    localparam int CW = $clog2(N + 1);

    logic [M:0]   r_rem;
    logic [N-1:0] r_quo;
    logic [M-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [M:0]   shifted;
    logic         ge;

    assign shifted = {r_rem[M-1:0], r_quo[N-1]};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - {1'b0, r_dvs}) : shifted;
            r_quo <= {r_quo[N-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> rtl/tgl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgl_datapath
// Registers, arithmetic steps and result register of the tissue compartment.
// ----------------------------------------------------------------------------
module tgl_datapath
    import tgl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [23:0]        i_pressure_value,
    input  logic [19:0]        i_duration,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [23:0]        o_tissue_pressure,
    output logic signed [23:0] o_surface_tolerance,
    output logic signed [23:0] o_gradient,
    output logic [1:0]         o_status
);
    logic [19:0] r_half_life;
    logic [23:0] r_coeff_a;
    logic [15:0] r_coeff_b;
    logic [15:0] r_vapour;
    logic [23:0] r_press;
    logic        r_press_valid;

    logic        r_req;
    logic [23:0] r_pv;
    logic [19:0] r_dur;

    logic [23:0] r_interp;
    logic [4:0]  r_idx;
    logic [4:0]  r_n;
    logic        r_shift_zero;
    logic [16:0] r_f;
    logic signed [25:0] r_diff;
    logic signed [43:0] r_prod;
    logic signed [25:0] r_tol;
    logic        r_neg;
    logic        r_den_zero;

    logic        r_out_valid;
    logic [23:0] r_o_press;
    logic signed [23:0] r_o_tol;
    logic signed [23:0] r_o_grad;
    logic [1:0]  r_o_status;

    logic             div_start;
    logic [DIV_N-1:0] div_dividend;
    logic [DIV_M-1:0] div_divisor;
    logic             div_done;
    logic [DIV_N-1:0] div_q;

    logic [11:0] dtab;
    logic [16:0] v_interp;
    logic [16:0] v_shift;
    logic signed [26:0] p_sum;
    logic signed [24:0] p_minus_a;
    logic signed [41:0] tol_prod;
    logic signed [24:0] num;
    logic signed [26:0] den;
    logic [23:0] num_mag;
    logic [26:0] den_mag;
    logic signed [23:0] grad_sat;
    logic signed [23:0] tol_sat;

    assign dtab = 12'(f_exp2_tab({1'b0, div_q[15:12]}) - f_exp2_tab({1'b0, div_q[15:12]} + 5'd1));
    assign v_interp = f_exp2_tab(r_idx) - 17'((25'(r_interp) + 25'd2048) >> 12);
    assign v_shift  = r_shift_zero ? 17'd0 : (v_interp >> r_n);
    assign p_sum    = $signed({3'b0, r_press}) + 27'(f_round_q16(r_prod));
    assign p_minus_a = $signed({1'b0, r_press}) - $signed({1'b0, r_coeff_a});
    assign tol_prod = p_minus_a * $signed({1'b0, r_coeff_b});
    assign num      = $signed({1'b0, r_press}) - $signed({1'b0, r_pv});
    assign den      = $signed({3'b0, r_press}) - 27'(r_tol);
    assign num_mag  = num[24] ? 24'(-num) : 24'(num);
    assign den_mag  = den[26] ? 27'(-den) : 27'(den);

    assign div_start    = i_cmd.div_start_exp | i_cmd.den_start;
    assign div_dividend = i_cmd.den_start ? {num_mag, 16'd0} : {4'd0, r_dur, 16'd0};
    assign div_divisor  = i_cmd.den_start ? den_mag :
                          {7'd0, (r_half_life == 20'd0) ? 20'd1 : r_half_life};

    tgl_divider #(.N(DIV_N), .M(DIV_M)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        if (r_neg) begin
            grad_sat = (div_q > DIV_N'(8388608)) ? -24'sd8388608 : $signed(24'(-div_q));
        end else begin
            grad_sat = (div_q > DIV_N'(8388607)) ? 24'sd8388607 : $signed(div_q[23:0]);
        end
        if (r_tol > 26'sd8388607) begin
            tol_sat = 24'sd8388607;
        end else if (r_tol < -26'sd8388608) begin
            tol_sat = -24'sd8388608;
        end else begin
            tol_sat = r_tol[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_life   <= 20'd4096;
            r_coeff_a     <= 24'd82570;
            r_coeff_b     <= 16'd33096;
            r_vapour      <= 16'd4109;
            r_press       <= '0;
            r_press_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HALF_LIFE: r_half_life <= i_cfg_data[19:0];
                    CFG_COEFF_A:   r_coeff_a   <= i_cfg_data;
                    CFG_COEFF_B:   r_coeff_b   <= i_cfg_data[15:0];
                    CFG_VAPOUR:    r_vapour    <= i_cfg_data[15:0];
                    default:       r_vapour    <= r_vapour;
                endcase
            end
            if (i_cmd.set_press) begin
                r_press       <= r_pv;
                r_press_valid <= 1'b1;
            end else if (i_cmd.upd) begin
                if (p_sum < 27'sd0) begin
                    r_press <= '0;
                end else if (p_sum > 27'sd16777215) begin
                    r_press <= 24'hFFFFFF;
                end else begin
                    r_press <= p_sum[23:0];
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req_type;
            r_pv  <= i_pressure_value;
            r_dur <= i_duration;
        end
        if (i_cmd.exp_cap) begin
            r_interp     <= 24'(dtab * div_q[11:0]);
            r_idx        <= {1'b0, div_q[15:12]};
            r_n          <= div_q[20:16];
            r_shift_zero <= div_q[DIV_N-1:16] >= 24'd17;
        end
        if (i_cmd.fact) begin
            r_f    <= 17'd65536 - v_shift;
            r_diff <= $signed({2'b0, r_pv}) - $signed({10'b0, r_vapour})
                      - $signed({2'b0, r_press});
        end
        if (i_cmd.mul_d) begin
            r_prod <= r_diff * $signed({1'b0, r_f});
        end else if (i_cmd.tol_mul) begin
            r_prod <= 44'(tol_prod);
        end
        if (i_cmd.tol_rnd) begin
            r_tol <= 26'(f_round_q16(r_prod));
        end
        if (i_cmd.den_start) begin
            r_neg      <= num[24] ^ den[26];
            r_den_zero <= den == 27'sd0;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_uninit) begin
                r_o_press  <= '0;
                r_o_tol    <= '0;
                r_o_grad   <= '0;
                r_o_status <= ST_UNINIT;
            end else begin
                r_o_press  <= r_press;
                r_o_tol    <= tol_sat;
                r_o_grad   <= r_den_zero ? 24'sd0 : grad_sat;
                r_o_status <= r_den_zero ? ST_DEN_ZERO : ST_OK;
            end
        end
    end

    assign o_stat.req         = r_req;
    assign o_stat.press_valid = r_press_valid;
    assign o_stat.div_done    = div_done;
    assign o_stat.out_free    = !r_out_valid || i_ready;

    assign o_valid             = r_out_valid;
    assign o_tissue_pressure   = r_o_press;
    assign o_surface_tolerance = r_o_tol;
    assign o_gradient          = r_o_grad;
    assign o_status            = r_o_status;
endmodule

>>> rtl/tgl_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgl_controller
// Sequencer that steps the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module tgl_controller
    import tgl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIV_R, S_EXP, S_FACT, S_MUL_D, S_UPD,
        S_TOL_MUL, S_TOL_RND, S_DEN, S_DIV_G, S_FINISH, S_FIN_UNINIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        o_ready = r_state == S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.req == REQ_SET) begin
                    o_cmd.set_press = 1'b1;
                    n_state = S_TOL_MUL;
                end else if (!i_stat.press_valid) begin
                    n_state = S_FIN_UNINIT;
                end else begin
                    o_cmd.div_start_exp = 1'b1;
                    n_state = S_DIV_R;
                end
            end
            S_DIV_R:   if (i_stat.div_done) n_state = S_EXP;
            S_EXP: begin
                o_cmd.exp_cap = 1'b1;
                n_state = S_FACT;
            end
            S_FACT: begin
                o_cmd.fact = 1'b1;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.mul_d = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_TOL_MUL;
            end
            S_TOL_MUL: begin
                o_cmd.tol_mul = 1'b1;
                n_state = S_TOL_RND;
            end
            S_TOL_RND: begin
                o_cmd.tol_rnd = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den_start = 1'b1;
                n_state = S_DIV_G;
            end
            S_DIV_G:   if (i_stat.div_done) n_state = S_FINISH;
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN_UNINIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_uninit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> sim/tissue_gas_loading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tissue_gas_loading_checker
// Watches the request, result and register channels of the tissue gas
// loading unit, predicts every result from its own copy of the compartment
// state and registers, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tissue_gas_loading_checker
    import tgl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic               i_req_type,
    input  logic [23:0]        i_pressure_value,
    input  logic [19:0]        i_duration,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [23:0]        i_tissue_pressure,
    input  logic [23:0]        i_surface_tolerance,
    input  logic [23:0]        i_gradient,
    input  logic [1:0]         i_status,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct packed {
        logic [23:0] press;
        logic [23:0] tol;
        logic [23:0] grad;
        logic [1:0]  status;
    } t_tissue_result;

    localparam longint PRESS_MAX = 64'd16777215;
    localparam longint S24_MAX   = 64'sd8388607;
    localparam longint S24_MIN   = -64'sd8388608;

    localparam longint EXP2_Q16 [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    t_tissue_result expected_results[$];

    longint half_life_reg;
    longint coeff_a_reg;
    longint coeff_b_reg;
    longint vapour_reg;
    longint tissue_press;
    bit     press_loaded;
    int     mismatches;

    function automatic longint round_half_away(longint x);
        if (x >= 0)
            return (x + 32768) / 65536;
        return -((-x + 32768) / 65536);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint loading_factor(longint dur, longint hl);
        longint ratio;
        longint shift;
        longint frac;
        longint idx;
        longint t;
        longint e;
        if (hl == 0)
            hl = 1;
        ratio = (dur << 16) / hl;
        shift = ratio >> 16;
        frac  = ratio & 64'hFFFF;
        idx   = frac >> 12;
        t     = frac & 64'hFFF;
        e = EXP2_Q16[idx] - (((EXP2_Q16[idx] - EXP2_Q16[idx + 1]) * t + 2048) / 4096);
        if (shift >= 17)
            e = 0;
        else
            e = e >>> shift;
        return 65536 - e;
    endfunction

    function automatic t_tissue_result predict_compartment(logic req, logic [23:0] pv_bits,
                                                           logic [19:0] dur_bits);
        t_tissue_result r;
        longint pv;
        longint diff;
        longint tol;
        longint num;
        longint den;
        longint grad;
        pv   = longint'(pv_bits);
        grad = 0;
        r    = '0;
        if (req == REQ_SET) begin
            tissue_press = pv;
            press_loaded = 1'b1;
        end else begin
            if (!press_loaded) begin
                r.status = ST_UNINIT;
                return r;
            end
            diff = pv - vapour_reg - tissue_press;
            tissue_press = clamp(tissue_press +
                round_half_away(diff * loading_factor(longint'(dur_bits), half_life_reg)),
                0, PRESS_MAX);
        end
        tol = round_half_away((tissue_press - coeff_a_reg) * coeff_b_reg);
        num = tissue_press - pv;
        den = tissue_press - tol;
        r.status = ST_OK;
        if (den == 0)
            r.status = ST_DEN_ZERO;
        else
            grad = clamp((num * 65536) / den, S24_MIN, S24_MAX);
        r.press = tissue_press[23:0];
        r.tol   = 24'(clamp(tol, S24_MIN, S24_MAX));
        r.grad  = 24'(grad);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tissue_result exp_r;
        t_tissue_result got;
        if (!i_rst_n) begin
            half_life_reg = 4096;
            coeff_a_reg   = 82570;
            coeff_b_reg   = 33096;
            vapour_reg    = 4109;
            tissue_press  = 0;
            press_loaded  = 1'b0;
            expected_results.delete();
            mismatches    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_LIFE: half_life_reg = longint'(i_cfg_data[19:0]);
                    CFG_COEFF_A:   coeff_a_reg   = longint'(i_cfg_data);
                    CFG_COEFF_B:   coeff_b_reg   = longint'(i_cfg_data[15:0]);
                    CFG_VAPOUR:    vapour_reg    = longint'(i_cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in)
                expected_results.push_back(
                    predict_compartment(i_req_type, i_pressure_value, i_duration));
            if (i_res_valid && i_res_ready) begin
                got = '{i_tissue_pressure, i_surface_tolerance, i_gradient, i_status};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result transaction with no expectation: P=%h T=%h G=%h S=%0d",
                                 $realtime, got.press, got.tol, got.grad, got.status);
                    mismatches = mismatches + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch exp P=%h T=%h G=%h S=%0d got P=%h T=%h G=%h S=%0d",
                                     $realtime, exp_r.press, exp_r.tol, exp_r.grad,
                                     exp_r.status, got.press, got.tol, got.grad, got.status);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

    assign o_fail_count = mismatches;

endmodule

>>> sim/tissue_gas_loading_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tissue_gas_loading_unit_test
// Drives the tissue gas loading unit with directed and random set and update
// transactions under several register settings and random stalls on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tissue_gas_loading_unit_test;
    import tgl_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_req_type;
    logic [23:0]        i_pressure_value;
    logic [19:0]        i_duration;
    logic               o_valid;
    logic               i_ready;
    logic [23:0]        o_tissue_pressure;
    logic signed [23:0] o_surface_tolerance;
    logic signed [23:0] o_gradient;
    logic [1:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;

    int pending;
    int fail_count;
    bit no_stall = 1'b0;

    tissue_gas_loading_unit dut (.*);

    tissue_gas_loading_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_req_type(i_req_type),
        .i_pressure_value(i_pressure_value), .i_duration(i_duration),
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_tissue_pressure(o_tissue_pressure), .i_surface_tolerance(o_surface_tolerance),
        .i_gradient(o_gradient), .i_status(o_status),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_request(logic req, logic [23:0] pv, logic [19:0] dur);
        int gap;
        bit taken;
        gap = no_stall ? 0 : $urandom_range(16, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_req_type       <= req;
        i_pressure_value <= pv;
        i_duration       <= dur;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [23:0] value);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(logic [19:0] hl, logic [23:0] a, logic [15:0] b,
                                 logic [15:0] vap);
        drain_results();
        write_register(CFG_HALF_LIFE, {4'(0), hl});
        write_register(CFG_COEFF_A, a);
        write_register(CFG_COEFF_B, {8'(0), b});
        write_register(CFG_VAPOUR, {8'(0), vap});
    endtask

    task automatic random_requests(int count);
        logic        req;
        logic [23:0] pv;
        logic [19:0] dur;
        for (int k = 0; k < count; k++) begin
            req = ($urandom_range(3, 0) != 0) ? REQ_UPDATE : REQ_SET;
            case ($urandom_range(3, 0))
                0:       pv = 24'($urandom);
                1:       pv = 24'($urandom_range(24'h0FFFFF, 0));
                default: pv = 24'($urandom_range(24'h0A0000, 24'h010000));
            endcase
            case ($urandom_range(3, 0))
                0:       dur = 20'($urandom);
                1:       dur = 20'($urandom_range(255, 0));
                default: dur = 20'($urandom_range(20'h1FFFF, 0));
            endcase
            send_request(req, pv, dur);
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_req_type       <= REQ_SET;
        i_pressure_value <= '0;
        i_duration       <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_HALF_LIFE;
        i_cfg_data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An update before any set finds the compartment uninitialized.
        send_request(REQ_UPDATE, 24'h020000, 20'd4096);
        send_request(REQ_SET, 24'hFFFFFF, 20'hFFFFF);
        send_request(REQ_UPDATE, 24'h000000, 20'd0);
        send_request(REQ_UPDATE, 24'h000000, 20'hFFFFF);
        send_request(REQ_UPDATE, 24'hFFFFFF, 20'hFFFFF);
        send_request(REQ_SET, 24'h000000, 20'd0);
        send_request(REQ_UPDATE, 24'hFFFFFF, 20'd1);
        send_request(REQ_UPDATE, 24'h010000, 20'd69632);
        send_request(REQ_SET, 24'h010000, 20'd0);
        send_request(REQ_UPDATE, 24'h040000, 20'd2048);
        send_request(REQ_UPDATE, 24'h010000, 20'd4095);
        random_requests(100);

        // With a zero coefficient a, a zero tissue pressure zeroes the denominator.
        load_settings(20'd1, 24'd0, 16'd0, 16'd0);
        send_request(REQ_SET, 24'h000000, 20'd0);
        send_request(REQ_UPDATE, 24'h000000, 20'd5);
        send_request(REQ_UPDATE, 24'hFFFFFF, 20'd0);
        random_requests(90);

        load_settings(20'hFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SET, 24'h000000, 20'd0);
        send_request(REQ_UPDATE, 24'h000000, 20'hFFFFF);
        send_request(REQ_SET, 24'hFFFFFF, 20'd0);
        send_request(REQ_UPDATE, 24'h000000, 20'hFFFFF);
        no_stall = 1'b1;
        random_requests(90);
        no_stall = 1'b0;

        // A zero half-life is handled as the shortest one.
        load_settings(20'd0, 24'd82570, 16'd33096, 16'd4109);
        send_request(REQ_UPDATE, 24'h030000, 20'd3);
        random_requests(90);

        for (int phase = 0; phase < 3; phase++) begin
            load_settings(($urandom_range(1, 0) != 0) ? 20'($urandom_range(40000, 1000))
                                                      : 20'($urandom),
                          24'($urandom_range(24'h040000, 0)), 16'($urandom),
                          16'($urandom_range(8000, 0)));
            no_stall = (phase == 1);
            random_requests(90);
        end
        no_stall = 1'b0;

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int  gap;
        bit  taken;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = no_stall ? 0 : $urandom_range(16, 0);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                taken = o_valid;
                @(posedge i_clk);
            end while (!taken);
        end
    end

endmodule

>>> tissue_gas_loading_unit.f
rtl/tgl_pkg.sv
rtl/tgl_divider.sv
rtl/tgl_datapath.sv
rtl/tgl_controller.sv
rtl/tissue_gas_loading_unit.sv
sim/tissue_gas_loading_checker.sv
sim/tissue_gas_loading_unit_test.sv
